@@ hdl/gregorian_date_add_days_top_macros.svh @@
// Assertion macros used by the checker in gdad_checker.sv.
`ifndef GREGORIAN_DATE_ADD_DAYS_TOP_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GDAD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GDAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/gdad_pkg.sv @@
package gdad_pkg;

	localparam int unsigned MAX_DAYS_ADD = 4095;
	localparam logic [13:0] YEAR_LIMIT   = 14'd9999;
	localparam logic [8:0]  LEAP_CYCLE   = 9'd400;
	localparam logic [8:0]  CENTURY      = 9'd100;
	localparam logic [3:0]  LAST_MONTH   = 4'd12;
	localparam logic [4:0]  LEN_LONG     = 5'd31;
	localparam logic [4:0]  LEN_SHORT    = 5'd30;
	localparam logic [4:0]  LEN_FEB_LEAP = 5'd29;
	localparam logic [4:0]  LEN_FEB      = 5'd28;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [11:0] days_to_add;
	} req_t;

	typedef struct packed {
		logic [4:0]  new_day;
		logic [3:0]  new_month;
		logic [13:0] new_year;
		logic [8:0]  day_of_year;
		logic [1:0]  status;
	} res_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_REDUCE,
		OP_CHECK,
		OP_ORD,
		OP_ADD,
		OP_WALK,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_IF,
		BR_END
	} br_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] arg;
		br_t        br;
		logic [3:0] target;
	} ucode_t;

	typedef struct packed {
		logic       load;
		op_t        op;
		logic [2:0] arg;
	} ctrl_t;

	localparam logic [3:0] PC_ORD  = 4'd6;
	localparam logic [3:0] PC_WALK = 4'd8;
	localparam logic [3:0] PC_DONE = 4'd9;

	// Microprogram: reduce year mod 400, validate, sum months, add, walk, emit.
	function automatic ucode_t ucode_rom(input logic [3:0] pc);
		ucode_t w;
		begin
			unique case (pc)
				4'd0: w = '{OP_REDUCE, 3'd4, BR_NEXT, 4'd0};
				4'd1: w = '{OP_REDUCE, 3'd3, BR_NEXT, 4'd0};
				4'd2: w = '{OP_REDUCE, 3'd2, BR_NEXT, 4'd0};
				4'd3: w = '{OP_REDUCE, 3'd1, BR_NEXT, 4'd0};
				4'd4: w = '{OP_REDUCE, 3'd0, BR_NEXT, 4'd0};
				4'd5: w = '{OP_CHECK,  3'd0, BR_IF,   PC_DONE};
				4'd6: w = '{OP_ORD,    3'd0, BR_IF,   PC_ORD};
				4'd7: w = '{OP_ADD,    3'd0, BR_NEXT, 4'd0};
				4'd8: w = '{OP_WALK,   3'd0, BR_IF,   PC_WALK};
				4'd9: w = '{OP_DONE,   3'd0, BR_END,  4'd0};
				default: w = '{OP_NOP, 3'd0, BR_END,  4'd0};
			endcase
			return w;
		end
	endfunction

	// Leap test on year mod 400.
	function automatic logic leap_of(input logic [8:0] r);
		begin
			return (r[1:0] == 2'b00) && (r != CENTURY) && (r != 9'(2 * CENTURY))
				&& (r != 9'(3 * CENTURY));
		end
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		begin
			unique case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_LONG;
				4'd4, 4'd6, 4'd9, 4'd11:                    len = LEN_SHORT;
				4'd2:    len = leap ? LEN_FEB_LEAP : LEN_FEB;
				default: len = 5'd0;
			endcase
			return len;
		end
	endfunction

endpackage

@@ hdl/gdad_datapath.sv @@
module gdad_datapath (
	input  logic            clk,
	input  gdad_pkg::ctrl_t ctrl,
	input  gdad_pkg::req_t  req,
	output logic            cond,
	output gdad_pkg::res_t  result
);

	logic [12:0] day_q;
	logic [3:0]  mon_q;
	logic [13:0] year_q;
	logic [13:0] rem_q;
	logic [11:0] add_q;
	logic [8:0]  ord_q;
	logic [3:0]  k_q;
	logic        bad_q;
	gdad_pkg::res_t result_q;

	logic        leap;
	logic [3:0]  len_idx;
	logic [4:0]  len;
	logic [13:0] red_thr;
	logic        bad;

	assign leap    = gdad_pkg::leap_of(rem_q[8:0]);
	assign len_idx = (ctrl.op == gdad_pkg::OP_ORD) ? k_q : mon_q;
	assign len     = gdad_pkg::month_len(len_idx, leap);
	assign red_thr = 14'(gdad_pkg::LEAP_CYCLE) << ctrl.arg;
	assign bad     = (year_q > gdad_pkg::YEAR_LIMIT) || (mon_q == 4'd0)
		|| (mon_q > gdad_pkg::LAST_MONTH) || (day_q == 13'd0) || (day_q > 13'(len));

	always_comb begin
		unique case (ctrl.op)
			gdad_pkg::OP_CHECK: cond = bad;
			gdad_pkg::OP_ORD:   cond = k_q < mon_q;
			gdad_pkg::OP_WALK:  cond = day_q > 13'(len);
			default:            cond = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			day_q  <= 13'(req.start_day);
			mon_q  <= req.start_month;
			year_q <= req.start_year;
			rem_q  <= req.start_year;
			// saturate the count
			if (32'(req.days_to_add) > gdad_pkg::MAX_DAYS_ADD)
				add_q <= 12'(gdad_pkg::MAX_DAYS_ADD);
			else
				add_q <= req.days_to_add;
		end else begin
			unique case (ctrl.op)
				gdad_pkg::OP_REDUCE: begin
					if (rem_q >= red_thr)
						rem_q <= rem_q - red_thr;
				end
				gdad_pkg::OP_CHECK: begin
					bad_q <= bad;
					ord_q <= 9'(day_q);
					k_q   <= 4'd1;
				end
				gdad_pkg::OP_ORD: begin
					if (cond) begin
						ord_q <= ord_q + 9'(len);
						k_q   <= k_q + 4'd1;
					end
				end
				gdad_pkg::OP_ADD: begin
					day_q <= day_q + 13'(add_q);
				end
				gdad_pkg::OP_WALK: begin
					if (cond) begin
						day_q <= day_q - 13'(len);
						// wrap into January and advance the year and its leap phase
						if (mon_q == gdad_pkg::LAST_MONTH) begin
							mon_q  <= 4'd1;
							year_q <= year_q + 14'd1;
							if (rem_q == 14'(gdad_pkg::LEAP_CYCLE - 9'd1))
								rem_q <= 14'd0;
							else
								rem_q <= rem_q + 14'd1;
						end else begin
							mon_q <= mon_q + 4'd1;
						end
					end
				end
				gdad_pkg::OP_DONE: begin
					if (bad_q) begin
						result_q <= '{5'd0, 4'd0, 14'd0, 9'd0, gdad_pkg::ST_INVALID};
					end else if (year_q > gdad_pkg::YEAR_LIMIT) begin
						result_q <= '{5'd0, 4'd0, gdad_pkg::YEAR_LIMIT, ord_q,
							gdad_pkg::ST_OVERFLOW};
					end else begin
						result_q <= '{day_q[4:0], mon_q, year_q, ord_q, gdad_pkg::ST_OK};
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result = result_q;

endmodule

@@ hdl/gregorian_date_add_days_top.sv @@
// Gregorian date adder. Raise start with a request while busy is low; the
// request is taken at that edge and busy stays high until the result is
// shown. The result sits on result for exactly one cycle with done high and
// must be captured then: there is no way to hold it off. A valid request runs
// longer the later its start month and the more months the addition crosses,
// since the microcode sums the months before the start and then walks month by
// month; an invalid date skips from the check to the result step, with no walk.
// A new request may be given in the cycle that done is high.
module gregorian_date_add_days_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gdad_pkg::req_t req,
	output logic           done,
	output gdad_pkg::res_t result
);

	logic [3:0]       pc_q;
	logic             busy_q;
	logic             done_q;
	gdad_pkg::ucode_t uword;
	gdad_pkg::ctrl_t  ctrl;
	logic             accept;
	logic             cond;

	assign accept = start && !busy_q;
	assign uword  = gdad_pkg::ucode_rom(pc_q);

	always_comb begin
		ctrl.load = accept;
		ctrl.op   = busy_q ? uword.op : gdad_pkg::OP_NOP;
		ctrl.arg  = uword.arg;
	end

	gdad_datapath u_dp (
		.clk    (clk),
		.ctrl   (ctrl),
		.req    (req),
		.cond   (cond),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= 4'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				pc_q   <= 4'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				unique case (uword.br)
					gdad_pkg::BR_NEXT: pc_q <= pc_q + 4'd1;
					gdad_pkg::BR_IF:   pc_q <= cond ? uword.target : pc_q + 4'd1;
					gdad_pkg::BR_END: begin
						pc_q   <= 4'd0;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: pc_q <= 4'd0;
				endcase
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ hdl/gdad_checker.sv @@
`include "gregorian_date_add_days_top_macros.svh"

module gdad_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input gdad_pkg::res_t result
);

	`GDAD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but busy not raised")
	`GDAD_ASSERT_NOW(a_done_idle, done, !busy && $past(busy), "done without a request in flight")
	`GDAD_ASSERT_NOW(a_invalid_zero, done && result.status == gdad_pkg::ST_INVALID,
		result.new_day == 5'd0 && result.new_month == 4'd0 && result.new_year == 14'd0 &&
		result.day_of_year == 9'd0, "invalid result with non-zero fields")
	`GDAD_ASSERT_NOW(a_ok_fields, done && result.status == gdad_pkg::ST_OK,
		result.new_day != 5'd0 && result.new_month != 4'd0 && result.day_of_year != 9'd0 &&
		result.new_year <= gdad_pkg::YEAR_LIMIT, "ok result out of range")
	`GDAD_ASSERT_NOW(a_status_code, done, result.status == gdad_pkg::ST_OK ||
		result.status == gdad_pkg::ST_INVALID || result.status == gdad_pkg::ST_OVERFLOW,
		"unknown status code")

endmodule

bind gregorian_date_add_days_top gdad_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ tb/sv/gregorian_date_add_days_checker.sv @@
module gregorian_date_add_days_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  gdad_pkg::req_t  req,
	input  logic            done,
	input  gdad_pkg::res_t  result,
	output int unsigned     fail_count,
	output int unsigned     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		gdad_pkg::req_t asked;
		gdad_pkg::res_t want;
	} dated_request_t;

	dated_request_t expected_dates[$];
	int unsigned    errors = 0;

	function automatic bit is_leap(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(int unsigned m, int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return is_leap(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Date reached after the requested count, plus the ordinal of the start date.
	function automatic gdad_pkg::res_t date_after(gdad_pkg::req_t r);
		gdad_pkg::res_t o;
		int unsigned    d;
		int unsigned    m;
		int unsigned    y;
		int unsigned    n;
		int unsigned    ord;
		int unsigned    k;
		o = '0;
		d = r.start_day;
		m = r.start_month;
		y = r.start_year;
		n = r.days_to_add;
		if (n > gdad_pkg::MAX_DAYS_ADD)
			n = gdad_pkg::MAX_DAYS_ADD;
		if (y > gdad_pkg::YEAR_LIMIT || m < 1 || m > gdad_pkg::LAST_MONTH || d < 1
			|| d > month_days(m, y)) begin
			o.status = gdad_pkg::ST_INVALID;
			return o;
		end
		ord = d;
		for (k = 1; k < m; k++)
			ord += month_days(k, y);
		d += n;
		while (d > month_days(m, y)) begin
			d -= month_days(m, y);
			m++;
			if (m > gdad_pkg::LAST_MONTH) begin
				m = 1;
				y++;
			end
		end
		o.day_of_year = 9'(ord);
		if (y > gdad_pkg::YEAR_LIMIT) begin
			o.new_year = gdad_pkg::YEAR_LIMIT;
			o.status   = gdad_pkg::ST_OVERFLOW;
		end else begin
			o.new_day   = 5'(d);
			o.new_month = 4'(m);
			o.new_year  = 14'(y);
			o.status    = gdad_pkg::ST_OK;
		end
		return o;
	endfunction

	task automatic flag_mismatch(string what);
		$display("%0t: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dated_request_t e;
		string          ctx;
		if (!arst_n) begin
			expected_dates.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					flag_mismatch($sformatf("result %p with no request waiting", result));
				end else begin
					e   = expected_dates.pop_front();
					ctx = $sformatf("%0d/%0d/%0d +%0d", e.asked.start_day,
						e.asked.start_month, e.asked.start_year, e.asked.days_to_add);
					if (result.new_day !== e.want.new_day)
						flag_mismatch($sformatf("%s new_day got %0d want %0d", ctx,
							result.new_day, e.want.new_day));
					if (result.new_month !== e.want.new_month)
						flag_mismatch($sformatf("%s new_month got %0d want %0d", ctx,
							result.new_month, e.want.new_month));
					if (result.new_year !== e.want.new_year)
						flag_mismatch($sformatf("%s new_year got %0d want %0d", ctx,
							result.new_year, e.want.new_year));
					if (result.day_of_year !== e.want.day_of_year)
						flag_mismatch($sformatf("%s day_of_year got %0d want %0d", ctx,
							result.day_of_year, e.want.day_of_year));
					if (result.status !== e.want.status)
						flag_mismatch($sformatf("%s status got %0d want %0d", ctx,
							result.status, e.want.status));
				end
			end
			if (start && !busy) begin
				e.asked = req;
				e.want  = date_after(req);
				expected_dates.push_back(e);
			end
			pending <= expected_dates.size();
		end
		fail_count <= errors;
	end

endmodule

@@ tb/sv/gregorian_date_add_days_top_tb.sv @@
module gregorian_date_add_days_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PHASE_REQUESTS = 650;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	gdad_pkg::req_t req = '0;
	logic           done;
	gdad_pkg::res_t result;
	int unsigned    fail_count;
	int unsigned    pending;

	always #5 clk = ~clk;

	gregorian_date_add_days_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	gregorian_date_add_days_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic gdad_pkg::req_t date_request(int unsigned d, int unsigned m,
		int unsigned y, int unsigned n);
		gdad_pkg::req_t r;
		r.start_day   = 5'(d);
		r.start_month = 4'(m);
		r.start_year  = 14'(y);
		r.days_to_add = 12'(n);
		return r;
	endfunction

	function automatic int unsigned month_cap(int unsigned m, int unsigned y);
		if (m == 2)
			return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
		return (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
	endfunction

	function automatic gdad_pkg::req_t random_request();
		int unsigned pick;
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 4) begin
			// bad month, anything else
			m = $urandom_range(1) ? 0 : $urandom_range(15, 13);
			return date_request($urandom_range(31), m, $urandom_range(9999), $urandom);
		end
		if (pick < 8) begin
			m = $urandom_range(12, 1);
			y = $urandom_range(9999);
			d = (month_cap(m, y) == 31 || $urandom_range(2) == 0) ? 0
				: $urandom_range(31, month_cap(m, y) + 1);
			return date_request(d, m, y, $urandom);
		end
		if (pick < 11)
			return date_request($urandom_range(31, 1), $urandom_range(12, 1),
				$urandom_range(16383, 10000), $urandom);
		pick = $urandom_range(99);
		if (pick < 55) begin
			y = $urandom_range(9999);
		end else if (pick < 72) begin
			y = $urandom_range(9999, 9985);
		end else if (pick < 90) begin
			// around century and quad-century years
			y = $urandom_range(24) * 400 + $urandom_range(3) * 100 + $urandom_range(2);
			if (y > 0)
				y = y - 1;
		end else begin
			y = $urandom_range(10);
		end
		m = $urandom_range(12, 1);
		d = ($urandom_range(3) == 0) ? month_cap(m, y) - $urandom_range(1)
			: $urandom_range(month_cap(m, y), 1);
		pick = $urandom_range(99);
		if (pick < 40)
			n = $urandom_range(4095);
		else if (pick < 65)
			n = $urandom_range(40);
		else if (pick < 85)
			n = $urandom_range(400);
		else if (pick < 95)
			n = $urandom_range(4095, 4000);
		else
			n = $urandom_range(1);
		return date_request(d, m, y, n);
	endfunction

	// Offer one request, dropping start at random cycles, until it is taken.
	task automatic offer_date(gdad_pkg::req_t r, int unsigned idle_pct);
		bit taken;
		@(negedge clk);
		req = r;
		do begin
			start = ($urandom_range(99) >= idle_pct);
			// busy only moves at the rising edge, so this is what that edge sees
			taken = start && !busy;
			@(posedge clk);
			if (!taken)
				@(negedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned idle_pct[3];
		idle_pct = '{25, 88, 0};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		offer_date(date_request(1, 1, 0, 0), 0);
		offer_date(date_request(31, 12, 9999, 0), 0);
		offer_date(date_request(31, 12, 9999, 1), 0);
		offer_date(date_request(28, 2, 1900, 1), 0);
		offer_date(date_request(28, 2, 2000, 1), 0);
		offer_date(date_request(29, 2, 2000, 0), 0);
		offer_date(date_request(29, 2, 1900, 0), 0);
		offer_date(date_request(29, 2, 2024, 4095), 0);
		offer_date(date_request(31, 12, 2023, 1), 0);
		offer_date(date_request(31, 1, 2023, 1), 0);
		offer_date(date_request(30, 4, 2023, 31), 0);
		offer_date(date_request(31, 12, 2100, 59), 0);
		offer_date(date_request(15, 0, 2020, 10), 0);
		offer_date(date_request(15, 13, 2020, 10), 0);
		offer_date(date_request(31, 15, 16383, 4095), 0);
		offer_date(date_request(0, 6, 2020, 10), 0);
		offer_date(date_request(31, 4, 2020, 10), 0);
		offer_date(date_request(10, 10, 10000, 5), 0);
		offer_date(date_request(1, 1, 16383, 0), 0);
		offer_date(date_request(1, 1, 9989, 4095), 0);
		offer_date(date_request(1, 1, 9988, 4095), 0);
		offer_date(date_request(31, 12, 9988, 4095), 0);
		offer_date(date_request(1, 3, 400, 4095), 0);
		drain();

		for (int p = 0; p < 3; p++) begin
			for (int unsigned i = 0; i < PHASE_REQUESTS; i++) begin
				offer_date(random_request(), idle_pct[p]);
				// hold back once mid-phase until the block has caught up
				if (i == PHASE_REQUESTS / 2)
					drain();
			end
			drain();
		end

		repeat (170) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
